// ===== src/sblac_pkg.sv =====
// shared constants for the superbee limited advection cell update
`timescale 1ns / 1ps
`default_nettype none

package sblac_pkg;

  // default value width (signed fixed point)
  localparam int VALUE_BITS_DEF = 16;

  // courant number register, unsigned q1.15
  localparam int                  CFL_BITS  = 16;
  localparam logic [CFL_BITS-1:0] CFL_RESET = 16'd32768;
  localparam int                  CFL_ONE   = 32768;
  localparam int                  CFL_FRAC  = 15;

  // c*(1-c)/2 in q16, signed; c = 1.0 gives zero
  localparam int                K_BITS  = 18;
  localparam logic [K_BITS-1:0] K_RESET = '0;

  // apb register map
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_CFL = 1'b0;

  // rounding of the final update term
  localparam int DELTA_SHIFT = 16;

endpackage

`default_nettype wire

// ===== src/superbee_limited_advection_cell_update_core.sv =====
// superbee flux limited lax-wendroff cell update, five stage pipeline
`timescale 1ns / 1ps
`default_nettype none

// an accepted input word passes through the five register stages to the result word on the outputs
// throughput: one word per cycle; the five register stages each move every cycle
// unless a stage holds a word that the next stage cannot take
// stall on the output backs up stage by stage, bubbles are squeezed out on the way
// reset: valid bits cleared, courant number set to 1.0, derived coefficient cleared
module superbee_limited_advection_cell_update_core #(
  parameter int VALUE_BITS = sblac_pkg::VALUE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [VALUE_BITS-1:0]  far_upwind_i,
  input  wire logic signed [VALUE_BITS-1:0]  near_upwind_i,
  input  wire logic signed [VALUE_BITS-1:0]  centre_value_i,
  input  wire logic signed [VALUE_BITS-1:0]  downwind_value_i,
  input  wire logic                          first_cell_i,
  // output channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [VALUE_BITS-1:0]       new_value_o,
  output logic                               saturated_o,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sblac_pkg::PADDR_W-1:0] paddr,
  input  wire logic [sblac_pkg::PDATA_W-1:0] pwdata,
  output logic [sblac_pkg::PDATA_W-1:0]      prdata,
  output logic                               pready
);

  localparam int W      = VALUE_BITS;
  localparam int DW     = W + 1;   // stencil differences
  localparam int BW     = W + 3;   // limited slopes
  localparam int BDW    = W + 4;   // slope difference
  localparam int M1W    = W + 18;  // c * d1
  localparam int PW     = W + 22;  // k * (b0 - b1)
  localparam int SW     = W + 23;  // full update sum
  localparam int RW     = SW - sblac_pkg::DELTA_SHIFT + 1; // centre minus delta
  localparam int NSTAGE = 5;

  // ---------------------------------------------------------------------------
  // configuration: courant number and the derived coefficient k = c*(1-c)/2
  // ---------------------------------------------------------------------------
  logic [sblac_pkg::CFL_BITS-1:0]      cfl_q;
  logic signed [sblac_pkg::K_BITS-1:0] k_q, k_d;
  logic                                cfg_wr;
  logic [sblac_pkg::REG_IDX_W-1:0]     reg_idx;
  logic signed [33:0]                  k_prod;
  logic signed [33:0]                  k_round;

  assign pready  = 1'b1;
  assign reg_idx = paddr[sblac_pkg::PADDR_W-1 -: sblac_pkg::REG_IDX_W];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    if (reg_idx == sblac_pkg::REG_CFL) begin
      prdata = sblac_pkg::PDATA_W'(cfl_q);
    end else begin
      prdata = '0;
    end
  end

  // c in [0, 65535], 1-c may go negative above 1.0; product stays inside 34 bits
  assign k_prod  = $signed({1'b0, cfl_q})
                 * ($signed(17'(sblac_pkg::CFL_ONE)) - $signed({1'b0, cfl_q}));
  // round to nearest, ties toward +inf
  assign k_round = k_prod + 34'sd16384;
  assign k_d     = sblac_pkg::K_BITS'(k_round >>> sblac_pkg::CFL_FRAC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfl_q <= sblac_pkg::CFL_RESET;
      k_q   <= sblac_pkg::K_RESET;
    end else begin
      if (cfg_wr && reg_idx == sblac_pkg::REG_CFL) begin
        cfl_q <= pwdata[sblac_pkg::CFL_BITS-1:0];
      end
      // k is registered from cfl and follows it in the next cycle, before any new word reaches stage three
      k_q <= k_d;
    end
  end

  // ---------------------------------------------------------------------------
  // superbee limiter; zero counts as negative
  // ---------------------------------------------------------------------------
  function automatic logic signed [BW-1:0] superbee(input logic signed [DW-1:0] a,
                                                    input logic signed [DW-1:0] b);
    logic          pa;
    logic          pb;
    logic [DW-1:0] ma;
    logic [DW-1:0] mb;
    logic          near_ok;
    logic [DW:0]   r;
    pa = !a[DW-1] && (a != '0);
    pb = !b[DW-1] && (b != '0);
    ma = a[DW-1] ? DW'(-a) : DW'(a);
    mb = b[DW-1] ? DW'(-b) : DW'(b);
    // magnitudes within a factor of two, no division
    near_ok = (a != '0) && (b != '0) && ({ma, 1'b0} >= {1'b0, mb})
              && ({mb, 1'b0} >= {1'b0, ma});
    if (near_ok) begin
      r = (ma > mb) ? {1'b0, ma} : {1'b0, mb};
    end else begin
      r = (ma < mb) ? {ma, 1'b0} : {mb, 1'b0};
    end
    if (pa != pb) begin
      superbee = '0;
    end else if (pa) begin
      superbee = $signed({1'b0, r});
    end else begin
      superbee = -$signed({1'b0, r});
    end
  endfunction

  // ---------------------------------------------------------------------------
  // pipeline handshake: a stage loads when it is empty or its word moves on
  // ---------------------------------------------------------------------------
  logic [NSTAGE-1:0] vld_q;
  logic [NSTAGE-1:0] adv;

  always_comb begin
    adv[NSTAGE-1] = !vld_q[NSTAGE-1] || !out_stall_i;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      adv[i] = !vld_q[i] || adv[i+1];
    end
  end

  assign in_stall_o = !adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (adv[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: stencil differences
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] d0_q, d1_q, d2_q;
  logic signed [DW-1:0] d0_d, d1_d, d2_d;
  logic signed [W-1:0]  ctr1_q;

  assign d0_d = DW'(downwind_value_i) - DW'(centre_value_i);
  assign d1_d = DW'(centre_value_i) - DW'(near_upwind_i);
  // on the first cell the far difference copies the near one
  assign d2_d = first_cell_i ? d1_d : DW'(near_upwind_i) - DW'(far_upwind_i);

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      d0_q   <= d0_d;
      d1_q   <= d1_d;
      d2_q   <= d2_d;
      ctr1_q <= centre_value_i;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: limited slopes and c*d1
  // ---------------------------------------------------------------------------
  logic signed [BW-1:0]  b0_q, b1_q;
  logic signed [M1W-1:0] m1_2_q;
  logic signed [W-1:0]   ctr2_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      b0_q   <= superbee(d0_q, d1_q);
      b1_q   <= superbee(d1_q, d2_q);
      m1_2_q <= M1W'($signed({1'b0, cfl_q}) * d1_q);
      ctr2_q <= ctr1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: k * (b0 - b1)
  // ---------------------------------------------------------------------------
  logic signed [BDW-1:0] bd;
  logic signed [PW-1:0]  prod_q;
  logic signed [M1W-1:0] m1_3_q;
  logic signed [W-1:0]   ctr3_q;

  assign bd = BDW'(b0_q) - BDW'(b1_q);

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      prod_q <= PW'(k_q * bd);
      m1_3_q <= m1_2_q;
      ctr3_q <= ctr2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: s = 2*c*d1 + k*(b0-b1), plus half an lsb of the final shift
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] m1_ext;
  logic signed [SW-1:0] sum_q;
  logic signed [W-1:0]  ctr4_q;

  assign m1_ext = SW'(m1_3_q);

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      sum_q  <= (m1_ext <<< 1) + SW'(prod_q)
              + (SW'(1) <<< (sblac_pkg::DELTA_SHIFT - 1));
      ctr4_q <= ctr3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: new = u - round(s / 2^16), saturated to the value range
  // ---------------------------------------------------------------------------
  logic signed [RW-1:0] delta;
  logic signed [RW-1:0] res;
  logic                 ovf;
  logic signed [W-1:0]  nv_d;
  logic signed [W-1:0]  nv_q;
  logic                 sat_q;

  assign delta = RW'(sum_q >>> sblac_pkg::DELTA_SHIFT);
  assign res   = RW'(ctr4_q) - delta;
  // out of range when the bits above the sign bit disagree with it
  assign ovf   = (res[RW-1:W-1] != '0) && (res[RW-1:W-1] != '1);

  always_comb begin
    if (!ovf) begin
      nv_d = res[W-1:0];
    end else if (res[RW-1]) begin
      nv_d = {1'b1, {(W-1){1'b0}}};
    end else begin
      nv_d = {1'b0, {(W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      nv_q  <= nv_d;
      sat_q <= ovf;
    end
  end

  assign out_valid_o = vld_q[NSTAGE-1];
  assign new_value_o = nv_q;
  assign saturated_o = sat_q;

endmodule

`default_nettype wire

// ===== src/sblac_checker.sv =====
// port level checks for the superbee cell update core, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module sblac_checker #(
  parameter int VALUE_BITS = sblac_pkg::VALUE_BITS_DEF
) (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_stall_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic signed [VALUE_BITS-1:0] new_value_o,
  input wire logic                         saturated_o
);

  localparam logic [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  // a stalled result word stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(new_value_o) && $stable(saturated_o))
    else $error("result word changed while stalled");

  // an empty output stage means the whole pipeline can move
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output stage");

  // a clipped result sits on a range limit
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> new_value_o == VMAX || new_value_o == VMIN)
    else $error("saturated result not at a range limit");

endmodule

bind superbee_limited_advection_cell_update_core sblac_checker #(
  .VALUE_BITS(VALUE_BITS)
) u_sblac_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .new_value_o(new_value_o),
  .saturated_o(saturated_o)
);

`default_nettype wire

// ===== tb/advection_cell_checker.sv =====
// checker for the advection cell update: predicts every result word and compares on arrival
`timescale 1ns / 1ps

module advection_cell_checker
  import sblac_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic signed [VALUE_BITS-1:0] far_upwind_i,
  input  logic signed [VALUE_BITS-1:0] near_upwind_i,
  input  logic signed [VALUE_BITS-1:0] centre_value_i,
  input  logic signed [VALUE_BITS-1:0] downwind_value_i,
  input  logic                         first_cell_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic signed [VALUE_BITS-1:0] new_value_i,
  input  logic                         saturated_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic                         pready_i,
  input  logic [PADDR_W-1:0]           paddr_i,
  input  logic [PDATA_W-1:0]           pwdata_i,
  output int                           fail_count_o,
  output int                           outstanding_o,
  output int                           checked_o,
  output int                           clipped_o
);

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic                         clipped;
  } cell_result_t;

  cell_result_t        pending_cells[$];
  cell_result_t        want;
  logic [CFL_BITS-1:0] courant_q = CFL_RESET;
  int                  mismatches = 0;
  int                  outstanding = 0;
  int                  checked = 0;
  int                  clipped = 0;

  assign fail_count_o  = mismatches;
  assign outstanding_o = outstanding;
  assign checked_o     = checked;
  assign clipped_o     = clipped;

  task automatic report_mismatch(input string what, input longint got, input longint exp_v);
    $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, exp_v);
    mismatches++;
  endtask

  // superbee slope; zero counts as negative
  function automatic longint superbee_slope(input longint a, input longint b);
    longint ma, mb, r;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    if ((a > 0) != (b > 0)) return 0;
    if (a != 0 && b != 0 && 2 * ma >= mb && 2 * mb >= ma) r = (ma > mb) ? ma : mb;
    else r = 2 * ((ma < mb) ? ma : mb);
    return (a > 0) ? r : -r;
  endfunction

  function automatic cell_result_t predict_cell(
    input logic signed [VALUE_BITS-1:0] far_v,
    input logic signed [VALUE_BITS-1:0] near_v,
    input logic signed [VALUE_BITS-1:0] ctr_v,
    input logic signed [VALUE_BITS-1:0] dwn_v,
    input logic                         first_v
  );
    longint       c, d0, d1, d2, b0, b1, k, s, res, hi, lo;
    cell_result_t r;
    c  = longint'(courant_q);
    d0 = longint'(dwn_v) - longint'(ctr_v);
    d1 = longint'(ctr_v) - longint'(near_v);
    d2 = first_v ? d1 : longint'(near_v) - longint'(far_v);
    b0 = superbee_slope(d0, d1);
    b1 = superbee_slope(d1, d2);
    // c*(1-c)/2 in q16, round half up
    k   = (c * (CFL_ONE - c) + (longint'(1) <<< (CFL_FRAC - 1))) >>> CFL_FRAC;
    s   = 2 * c * d1 + k * (b0 - b1);
    res = longint'(ctr_v) - ((s + (longint'(1) <<< (DELTA_SHIFT - 1))) >>> DELTA_SHIFT);
    hi  = (longint'(1) <<< (VALUE_BITS - 1)) - 1;
    lo  = -hi - 1;
    r.clipped = 1'b0;
    if (res > hi) begin
      res = hi;
      r.clipped = 1'b1;
    end else if (res < lo) begin
      res = lo;
      r.clipped = 1'b1;
    end
    r.value = res[VALUE_BITS-1:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (psel_i && penable_i && pwrite_i && pready_i && (paddr_i >> 2) == PADDR_W'(REG_CFL))
        courant_q = pwdata_i[CFL_BITS-1:0];
      if (in_valid_i && !in_stall_i)
        pending_cells.push_back(predict_cell(far_upwind_i, near_upwind_i, centre_value_i,
                                             downwind_value_i, first_cell_i));
      if (out_valid_i && !out_stall_i) begin
        if (pending_cells.size() == 0) begin
          report_mismatch("result word with nothing expected", new_value_i, 0);
        end else begin
          want = pending_cells.pop_front();
          if (new_value_i !== want.value)
            report_mismatch("new_value", new_value_i, want.value);
          if (saturated_i !== want.clipped)
            report_mismatch("saturated", saturated_i, want.clipped);
          checked++;
          if (want.clipped) clipped++;
        end
      end
      outstanding = pending_cells.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// testbench top for the superbee advection cell update: stimulus, idling and verdict
`timescale 1ns / 1ps

module tb_top;
  import sblac_pkg::*;

  localparam int VB = VALUE_BITS_DEF;
  // register index past the end of the map, writes there must be ignored
  localparam int REG_SPARE = 1;
  localparam logic [PADDR_W-1:0] ADDR_CFL   = PADDR_W'(REG_CFL) << 2;
  localparam logic [PADDR_W-1:0] ADDR_SPARE = PADDR_W'(REG_SPARE) << 2;
  localparam int RANDOM_PHASES = 8;
  localparam int CELLS_PER_PHASE = 230;

  typedef struct packed {
    logic signed [VB-1:0] far_v;
    logic signed [VB-1:0] near_v;
    logic signed [VB-1:0] ctr_v;
    logic signed [VB-1:0] dwn_v;
    logic                 first_v;
  } stencil_t;

  // receiver back-pressure modes
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // input channel
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [VB-1:0] far_upwind = '0;
  logic signed [VB-1:0] near_upwind = '0;
  logic signed [VB-1:0] centre_value = '0;
  logic signed [VB-1:0] downwind_value = '0;
  logic                 first_cell = 1'b0;

  // output channel
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [VB-1:0] new_value;
  logic                 saturated;

  // configuration port
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int fail_count, outstanding, checked, clipped;
  int cells_sent = 0;
  int settings_used = 0;
  int burst_left = 0;

  stall_mode_e stall_mode = STALL_NONE;
  int          stall_left = 0;

  always #1 clk = ~clk;

  superbee_limited_advection_cell_update_core #(
    .VALUE_BITS(VB)
  ) u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .far_upwind_i    (far_upwind),
    .near_upwind_i   (near_upwind),
    .centre_value_i  (centre_value),
    .downwind_value_i(downwind_value),
    .first_cell_i    (first_cell),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .new_value_o     (new_value),
    .saturated_o     (saturated),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  advection_cell_checker #(
    .VALUE_BITS(VB)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .far_upwind_i    (far_upwind),
    .near_upwind_i   (near_upwind),
    .centre_value_i  (centre_value),
    .downwind_value_i(downwind_value),
    .first_cell_i    (first_cell),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .new_value_i     (new_value),
    .saturated_i     (saturated),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .pready_i        (pready),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .fail_count_o    (fail_count),
    .outstanding_o   (outstanding),
    .checked_o       (checked),
    .clipped_o       (clipped)
  );

  // receiver stall pattern: stretches of one mode at a time, including no stall at all
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(5, 60);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_LIGHT:  out_stall <= ($urandom_range(0, 9) < 3);
      STALL_HEAVY:  out_stall <= ($urandom_range(0, 9) < 8);
      STALL_TOGGLE: out_stall <= ~out_stall;
      default:      out_stall <= 1'b0;
    endcase
  end

  // hard stop in case the pipeline hangs
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  function automatic stencil_t make_stencil(input longint far_v, input longint near_v,
                                            input longint ctr_v, input longint dwn_v,
                                            input logic first_v);
    stencil_t s;
    s.far_v   = far_v[VB-1:0];
    s.near_v  = near_v[VB-1:0];
    s.ctr_v   = ctr_v[VB-1:0];
    s.dwn_v   = dwn_v[VB-1:0];
    s.first_v = first_v;
    return s;
  endfunction

  // clip to the value range so smooth stencils stay smooth near the rails
  function automatic longint clip_value(input longint v);
    longint hi;
    hi = (longint'(1) <<< (VB - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint corner_value();
    case ($urandom_range(0, 5))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      3:       return -1;
      4:       return 1;
      default: return longint'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // mostly smooth profiles with a gradient and a little noise, so the limiter
  // sees every branch; the rest is raw noise and corner values such as the rails
  function automatic stencil_t random_stencil();
    stencil_t s;
    longint   base, grad, span;
    int       pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      case ($urandom_range(0, 3))
        0:       span = 1;
        1:       span = 16;
        2:       span = 512;
        default: span = 8192;
      endcase
      base = longint'($urandom_range(0, 40000)) - 20000;
      grad = longint'($urandom_range(0, 2 * span)) - span;
      s = make_stencil(
        clip_value(base - 2 * grad + longint'($urandom_range(0, span)) - span / 2),
        clip_value(base - grad + longint'($urandom_range(0, span)) - span / 2),
        clip_value(base),
        clip_value(base + grad + longint'($urandom_range(0, span)) - span / 2),
        1'b0);
    end else if (pick < 8) begin
      s = make_stencil(longint'($urandom), longint'($urandom), longint'($urandom),
                       longint'($urandom), 1'b0);
    end else begin
      s = make_stencil(corner_value(), corner_value(), corner_value(), corner_value(), 1'b0);
    end
    s.first_v = ($urandom_range(0, 7) == 0);
    return s;
  endfunction

  // one stencil word; opens a new burst after a random gap when the old one runs out
  task automatic send_cell(input stencil_t s);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    in_valid       <= 1'b1;
    far_upwind     <= s.far_v;
    near_upwind    <= s.near_v;
    centre_value   <= s.ctr_v;
    downwind_value <= s.dwn_v;
    first_cell     <= s.first_v;
    do @(posedge clk); while (in_stall);
    cells_sent++;
  endtask

  // stop sending and let every expected result word come out
  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    wait (outstanding == 0);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_courant(input logic [CFL_BITS-1:0] c);
    drain_pipeline();
    apb_write(ADDR_CFL, PDATA_W'(c));
    settings_used++;
  endtask

  initial begin : stimulus
    logic [CFL_BITS-1:0] courant_plan[RANDOM_PHASES];
    courant_plan = '{16'd0, 16'd65535, 16'd1, 16'd32767, 16'd32769, 16'd32768,
                     16'd0, 16'd0};
    courant_plan[6] = CFL_BITS'($urandom_range(0, 65535));
    courant_plan[7] = CFL_BITS'($urandom_range(0, 32768));

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // courant number at its reset value of one: result is the upwind cell
    settings_used++;
    send_cell(make_stencil(0, 0, 0, 0, 1'b0));
    send_cell(make_stencil(32767, 32767, 32767, 32767, 1'b0));
    send_cell(make_stencil(-32768, -32768, -32768, -32768, 1'b1));
    send_cell(make_stencil(0, -32768, 32767, 0, 1'b0));

    // half courant number so the limiter term is live
    set_courant(16'd16384);
    send_cell(make_stencil(-32768, -32768, 32767, -32768, 1'b0));
    // slopes of opposite sign give no limited slope
    send_cell(make_stencil(0, 100, 0, 50, 1'b0));
    // zero difference counts as negative
    send_cell(make_stencil(-200, -100, 0, 0, 1'b0));
    send_cell(make_stencil(5, 5, 5, 5, 1'b0));
    // ratio within two, exactly two, just beyond two
    send_cell(make_stencil(-300, -150, 0, 100, 1'b0));
    send_cell(make_stencil(-400, -200, 0, 100, 1'b0));
    send_cell(make_stencil(-402, -201, 0, 100, 1'b0));
    // falling profiles
    send_cell(make_stencil(300, 150, 0, -100, 1'b0));
    send_cell(make_stencil(600, 300, 0, -10, 1'b0));
    // first interior cell: far upwind value must not matter
    send_cell(make_stencil(-32768, -150, 0, 100, 1'b1));
    send_cell(make_stencil(32767, 150, 0, -100, 1'b1));
    // far difference of the other sign, and a large far difference of the same sign
    send_cell(make_stencil(100, -150, 0, 100, 1'b0));
    send_cell(make_stencil(-1000, -150, 0, 100, 1'b0));
    send_cell(make_stencil(0, -1, 0, 0, 1'b0));

    // courant number near two drives the update past both rails
    set_courant(16'd65535);
    send_cell(make_stencil(0, 32767, -32768, 0, 1'b0));
    send_cell(make_stencil(0, -32768, 32767, 0, 1'b0));

    // random phases, one courant setting each; a write past the map follows
    // every setting and must leave it alone
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_courant(courant_plan[p]);
      apb_write(ADDR_SPARE, $urandom);
      for (int n = 0; n < CELLS_PER_PHASE; n++) begin
        // one full pause mid-phase until every result word has come back
        if (p == RANDOM_PHASES / 2 && n == CELLS_PER_PHASE / 2) drain_pipeline();
        send_cell(random_stencil());
      end
    end

    drain_pipeline();
    repeat (20) @(posedge clk);

    $display("summary: %0d stencils over %0d courant settings, %0d result words compared",
             cells_sent, settings_used, checked);
    $display("summary: %0d of them clipped to the value range", clipped);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
